[sv/hkrb_pkg.sv]
// ----------------------------------------------------------------------------
// HID key report builder package
// Shared constants, command codes and types for the boot-keyboard report block.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrb_pkg;

  // Number of key slots held in the report state.
  localparam int KeySlots = 6;
  // Number of key slots that appear in every result word.
  localparam int ReportedSlots = 6;

  localparam logic [7:0] CapsCode    = 8'h39;
  localparam logic [7:0] ModFirst    = 8'hE0;
  localparam logic [7:0] ModLast     = 8'hE7;
  localparam logic [7:0] HostLedsRst = 8'hFF;
  localparam int         CapsLedBit  = 1;
  localparam int         LedDriveW   = 3;

  typedef enum logic [1:0] {
    CMD_KEY  = 2'd0,
    CMD_POLL = 2'd1,
    CMD_LED  = 2'd2
  } cmd_e;

  typedef logic [KeySlots-1:0][7:0] slot_vec_t;

  // One key action handed to the slot update logic.
  typedef struct packed {
    logic [7:0] code;
    logic       rel;
  } key_act_t;

endpackage

`default_nettype wire

[sv/hkrb_slot_update.sv]
// ----------------------------------------------------------------------------
// HID key report builder slot update
// Inserts a pressed code into the first empty slot or removes a released one.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrb_slot_update (
  input  hkrb_pkg::slot_vec_t slots_i,
  input  hkrb_pkg::key_act_t  act_i,
  output hkrb_pkg::slot_vec_t slots_o
);

  logic [hkrb_pkg::KeySlots-1:0] hit;
  logic [hkrb_pkg::KeySlots-1:0] hit_pre;
  logic [hkrb_pkg::KeySlots-1:0] empty;
  logic [hkrb_pkg::KeySlots-1:0] empty_seen;
  logic [hkrb_pkg::KeySlots-1:0] first_empty;
  hkrb_pkg::slot_vec_t           shifted;
  hkrb_pkg::slot_vec_t           inserted;
  logic                          found;

  for (genvar i = 0; i < hkrb_pkg::KeySlots; i++) begin : g_slot
    assign hit[i]   = (slots_i[i] == act_i.code);
    assign empty[i] = (slots_i[i] == 8'h00);

    // hit_pre marks the matching slot and every slot after it.
    if (i == 0) begin : g_first
      assign hit_pre[i]    = hit[i];
      assign empty_seen[i] = 1'b0;
    end else begin : g_rest
      assign hit_pre[i]    = hit_pre[i-1] | hit[i];
      assign empty_seen[i] = empty_seen[i-1] | empty[i-1];
    end

    assign first_empty[i] = empty[i] & ~empty_seen[i];
    assign inserted[i]    = first_empty[i] ? act_i.code : slots_i[i];

    if (i + 1 < hkrb_pkg::KeySlots) begin : g_shift
      assign shifted[i] = hit_pre[i] ? slots_i[i+1] : slots_i[i];
    end else begin : g_last
      assign shifted[i] = hit_pre[i] ? 8'h00 : slots_i[i];
    end
  end

  assign found = |hit;

  always_comb begin
    if (act_i.rel) begin
      slots_o = shifted;
    end else if (found) begin
      slots_o = slots_i;
    end else begin
      slots_o = inserted;
    end
  end

endmodule

`default_nettype wire

[sv/hid_key_report_builder_top.sv]
// ----------------------------------------------------------------------------
// HID key report builder
// Keeps a boot-keyboard report (key slots and modifier mask), handles caps
// lock as a toggle, tracks host LEDs, and gives one report word per item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  command, key_code, released,
//                                              host_leds
//   out      output     out_valid_o/out_stall_i slot0..slot5, modifier_bits,
//                                              report_changed, led_send,
//                                              keyboard_led_drive
//   cfg      input      cfg_we_i               caps_locking (cfg_wdata_i)
//
// One word is accepted every cycle while the input side is not stalled. A word
// is held in the input register, processed by the report logic, and its result
// is registered in the output register. The throughput is set by the single
// report update path, which reads and writes the report state once per cycle
// in which a word is processed.
// Reset clears the report to empty, the modifier mask to zero and the last
// host LED value to all ones; caps locking comes up enabled.
// A stall on the output holds the result register. If the input register also
// holds a word, it holds as well and the input side is stalled in the same
// cycle; an empty input register still takes one more word.
//
`default_nettype none

module hid_key_report_builder_top (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] key_code_i,
  input  logic       released_i,
  input  logic [7:0] host_leds_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] slot0_o,
  output logic [7:0] slot1_o,
  output logic [7:0] slot2_o,
  output logic [7:0] slot3_o,
  output logic [7:0] slot4_o,
  output logic [7:0] slot5_o,
  output logic [7:0] modifier_bits_o,
  output logic       report_changed_o,
  output logic       led_send_o,
  output logic [2:0] keyboard_led_drive_o,

  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  // Input register holding the word under processing.
  logic       in_valid_q;
  logic [1:0] cmd_q;
  logic [7:0] code_q;
  logic       rel_q;
  logic [7:0] leds_q;

  // Report state.
  hkrb_pkg::slot_vec_t slots_q, slots_d;
  logic [7:0]          mod_q, mod_d;
  logic                pending_q, pending_d;
  logic                caps_state_q, caps_state_d;
  logic                prev_led_q, prev_led_d;
  logic [7:0]          last_leds_q, last_leds_d;
  logic                caps_locking_q;

  // Result register.
  logic                          out_valid_q;
  logic [hkrb_pkg::ReportedSlots-1:0][7:0] out_slots_q;
  logic [hkrb_pkg::ReportedSlots-1:0][7:0] rep_slots;
  logic [7:0]                    out_mod_q;
  logic                          out_changed_q;
  logic                          out_send_q;
  logic [hkrb_pkg::LedDriveW-1:0] out_drive_q;

  logic                out_free;
  logic                fire;
  logic                in_take;
  logic                apply;
  logic                changed;
  logic                send;
  hkrb_pkg::key_act_t  act;
  hkrb_pkg::slot_vec_t slots_upd;

  // The result register can load when it is empty or its word leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= command_i;
      code_q <= key_code_i;
      rel_q  <= released_i;
      leds_q <= host_leds_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_locking_q <= 1'b1;
    end else if (cfg_we_i) begin
      caps_locking_q <= cfg_wdata_i;
    end
  end

  // Command decode. A caps word with locking that changes the lock state, and the
  // caps release on a poll tick, are both turned into an ordinary key action on the caps code.
  always_comb begin
    apply        = 1'b0;
    act.code     = code_q;
    act.rel      = rel_q;
    changed      = 1'b0;
    send         = 1'b0;
    pending_d    = pending_q;
    caps_state_d = caps_state_q;
    prev_led_d   = prev_led_q;
    last_leds_d  = last_leds_q;
    case (cmd_q)
      hkrb_pkg::CMD_KEY: begin
        changed = 1'b1;
        if (caps_locking_q && code_q == hkrb_pkg::CapsCode) begin
          // Only a change of the wanted lock state makes a momentary press.
          if (caps_state_q != !rel_q) begin
            caps_state_d = !rel_q;
            apply        = 1'b1;
            act.code     = hkrb_pkg::CapsCode;
            act.rel      = 1'b0;
            pending_d    = 1'b1;
          end
        end else begin
          apply = 1'b1;
        end
      end
      hkrb_pkg::CMD_POLL: begin
        if (pending_q) begin
          pending_d = 1'b0;
          apply     = 1'b1;
          act.code  = hkrb_pkg::CapsCode;
          act.rel   = 1'b1;
          changed   = 1'b1;
        end
      end
      hkrb_pkg::CMD_LED: begin
        if (leds_q != last_leds_q) begin
          last_leds_d = leds_q;
          send        = 1'b1;
          if (caps_locking_q && leds_q[hkrb_pkg::CapsLedBit] != prev_led_q) begin
            prev_led_d   = leds_q[hkrb_pkg::CapsLedBit];
            caps_state_d = leds_q[hkrb_pkg::CapsLedBit];
          end
        end
      end
      default: begin
      end
    endcase
  end

  hkrb_slot_update u_slot_update (
    .slots_i (slots_q),
    .act_i   (act),
    .slots_o (slots_upd)
  );

  // Code zero is ignored, modifier codes touch the mask, all others a slot.
  always_comb begin
    slots_d = slots_q;
    mod_d   = mod_q;
    if (apply && act.code != 8'h00) begin
      if (act.code inside {[hkrb_pkg::ModFirst:hkrb_pkg::ModLast]}) begin
        if (act.rel) begin
          mod_d = mod_q & ~(8'h01 << act.code[2:0]);
        end else begin
          mod_d = mod_q | (8'h01 << act.code[2:0]);
        end
      end else begin
        slots_d = slots_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q      <= '0;
      mod_q        <= 8'h00;
      pending_q    <= 1'b0;
      caps_state_q <= 1'b0;
      prev_led_q   <= 1'b0;
      last_leds_q  <= hkrb_pkg::HostLedsRst;
    end else if (fire) begin
      slots_q      <= slots_d;
      mod_q        <= mod_d;
      pending_q    <= pending_d;
      caps_state_q <= caps_state_d;
      prev_led_q   <= prev_led_d;
      last_leds_q  <= last_leds_d;
    end
  end

  // Slots beyond the stored count always report as empty.
  for (genvar j = 0; j < hkrb_pkg::ReportedSlots; j++) begin : g_rep
    if (j < hkrb_pkg::KeySlots) begin : g_held
      assign rep_slots[j] = slots_d[j];
    end else begin : g_none
      assign rep_slots[j] = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_slots_q   <= rep_slots;
      out_mod_q     <= mod_d;
      out_changed_q <= changed;
      out_send_q    <= send;
      out_drive_q   <= ~last_leds_d[hkrb_pkg::LedDriveW-1:0];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign slot0_o              = out_slots_q[0];
  assign slot1_o              = out_slots_q[1];
  assign slot2_o              = out_slots_q[2];
  assign slot3_o              = out_slots_q[3];
  assign slot4_o              = out_slots_q[4];
  assign slot5_o              = out_slots_q[5];
  assign modifier_bits_o      = out_mod_q;
  assign report_changed_o     = out_changed_q;
  assign led_send_o           = out_send_q;
  assign keyboard_led_drive_o = out_drive_q;

`ifndef ASSERT_OFF
  // The input side is only held back by a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A word in the input register with room downstream shows up as a result.
  a_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_free) |=> out_valid_o)
    else $error("processed word did not reach the result register");

  // A key or poll result and an LED result never come from the same word.
  a_flags_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(report_changed_o && led_send_o))
    else $error("report change and LED send flagged together");

  // The report state only moves when a word is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(mod_q) && $stable(slots_q) && $stable(last_leds_q)))
    else $error("report state changed without a word");
`endif

endmodule

`default_nettype wire

[tb/hid_key_report_builder_top_tb.sv]
// ----------------------------------------------------------------------------
// HID key report builder testbench
// Drives key, poll and LED words through the report block and checks every
// report word against a cycle-free predictor of the six-key boot report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_key_report_builder_top_tb;

  // The unused command value has no member in cmd_e, so it gets its own name.
  localparam logic [1:0] CmdUnused      = 2'd3;
  // Settling time waited after the last report is out.
  localparam int         SettleCycles   = 6;
  localparam int         WatchdogLimit  = 2000;
  localparam int         LongHoldCycles = 60;
  localparam int         PhaseWords     = 130;
  localparam int         NumPhases      = 5;
  // Ordinary keys come from a small pool so that repeats and releases hit.
  localparam logic [7:0] TypingBase     = 8'h04;

  // One report word as the block presents it on its output channel.
  typedef struct packed {
    hkrb_pkg::slot_vec_t slots;
    logic [7:0]          mods;
    logic                changed;
    logic                send;
    logic [2:0]          drive;
  } report_t;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  // One row of the directed table: either an input word or a register write.
  typedef struct packed {
    row_kind_e  kind;
    logic       cfg_value;
    logic [1:0] cmd;
    logic [7:0] code;
    logic       rel;
    logic [7:0] leds;
    logic       fixed;
    report_t    want;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] command_i;
  logic [7:0] key_code_i;
  logic       released_i;
  logic [7:0] host_leds_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] slot0_o;
  logic [7:0] slot1_o;
  logic [7:0] slot2_o;
  logic [7:0] slot3_o;
  logic [7:0] slot4_o;
  logic [7:0] slot5_o;
  logic [7:0] modifier_bits_o;
  logic       report_changed_o;
  logic       led_send_o;
  logic [2:0] keyboard_led_drive_o;
  logic       cfg_we_i;
  logic       cfg_wdata_i;

  hid_key_report_builder_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .command_i            (command_i),
    .key_code_i           (key_code_i),
    .released_i           (released_i),
    .host_leds_i          (host_leds_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .slot0_o              (slot0_o),
    .slot1_o              (slot1_o),
    .slot2_o              (slot2_o),
    .slot3_o              (slot3_o),
    .slot4_o              (slot4_o),
    .slot5_o              (slot5_o),
    .modifier_bits_o      (modifier_bits_o),
    .report_changed_o     (report_changed_o),
    .led_send_o           (led_send_o),
    .keyboard_led_drive_o (keyboard_led_drive_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  // Reports still owed by the block, oldest first.
  report_t   pending_reports[$];
  stim_row_t directed_rows[$];

  // A typed-in expectation travels with the word that it belongs to, so the
  // monitor can pick it up at the very edge where the word is accepted.
  logic      fix_valid;
  report_t   fix_report;

  // Control of the idle behavior on both sides.
  logic      sender_gaps;
  logic      stall_bursts;
  int        hold_requests;

  int        mismatches;
  int        words_out;
  int        quiet_cycles;

  // Shadow of the keyboard state, kept in step with every accepted word.
  logic [7:0] kb_slots [hkrb_pkg::KeySlots];
  logic [7:0] kb_mods;
  logic       kb_caps_pending;
  logic       kb_caps_on;
  logic       kb_prev_caps_led;
  logic [7:0] kb_last_leds;
  logic       kb_caps_locking;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Applies one press or release to the modifier mask or to the key slots.
  function automatic void apply_key_action(input logic [7:0] code, input logic rel);
    int         hit;
    int         k;
    logic [7:0] mod_bit;
    if (code == 8'h00) return;
    if (code >= hkrb_pkg::ModFirst && code <= hkrb_pkg::ModLast) begin
      mod_bit = 8'h01 << (code - hkrb_pkg::ModFirst);
      if (rel) kb_mods = kb_mods & ~mod_bit;
      else     kb_mods = kb_mods | mod_bit;
      return;
    end
    // Lowest slot that already holds this code, KeySlots when none does.
    hit = hkrb_pkg::KeySlots;
    for (k = hkrb_pkg::KeySlots - 1; k >= 0; k--) begin
      if (kb_slots[k] == code) hit = k;
    end
    if (rel) begin
      if (hit == hkrb_pkg::KeySlots) return;
      for (k = hit; k < hkrb_pkg::KeySlots - 1; k++) kb_slots[k] = kb_slots[k + 1];
      kb_slots[hkrb_pkg::KeySlots - 1] = 8'h00;
    end else if (hit == hkrb_pkg::KeySlots) begin
      // A new key goes into the first empty slot, or is lost when all are taken.
      for (k = hkrb_pkg::KeySlots - 1; k >= 0; k--) begin
        if (kb_slots[k] == 8'h00) hit = k;
      end
      if (hit < hkrb_pkg::KeySlots) kb_slots[hit] = code;
    end
  endfunction

  // Advances the shadow state by one word and returns the report it yields.
  function automatic report_t next_report(input logic [1:0] cmd, input logic [7:0] code,
                                          input logic rel, input logic [7:0] leds);
    report_t r;
    int      j;
    r.changed = 1'b0;
    r.send    = 1'b0;
    case (cmd)
      hkrb_pkg::CMD_KEY: begin
        r.changed = 1'b1;
        if (kb_caps_locking && code == hkrb_pkg::CapsCode) begin
          // Caps Lock as a toggle: only a change of lock state makes a press.
          if (kb_caps_on != !rel) begin
            kb_caps_on      = !rel;
            apply_key_action(hkrb_pkg::CapsCode, 1'b0);
            kb_caps_pending = 1'b1;
          end
        end else begin
          apply_key_action(code, rel);
        end
      end
      hkrb_pkg::CMD_POLL: begin
        if (kb_caps_pending) begin
          kb_caps_pending = 1'b0;
          apply_key_action(hkrb_pkg::CapsCode, 1'b1);
          r.changed       = 1'b1;
        end
      end
      hkrb_pkg::CMD_LED: begin
        if (leds != kb_last_leds) begin
          kb_last_leds = leds;
          r.send       = 1'b1;
          if (kb_caps_locking && leds[hkrb_pkg::CapsLedBit] != kb_prev_caps_led) begin
            kb_prev_caps_led = leds[hkrb_pkg::CapsLedBit];
            kb_caps_on       = leds[hkrb_pkg::CapsLedBit];
          end
        end
      end
      default: ;
    endcase
    for (j = 0; j < hkrb_pkg::ReportedSlots; j++) r.slots[j] = kb_slots[j];
    r.mods  = kb_mods;
    r.drive = ~kb_last_leds[hkrb_pkg::LedDriveW-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR report word %0d: %s", words_out, msg);
    mismatches++;
  endtask

  // The monitor checks the output side first, then takes in a register write
  // and finally predicts the word accepted on the input side at this edge.
  always @(posedge clk_i or negedge rst_ni) begin : report_monitor
    report_t got;
    report_t want;
    int      s;
    if (!rst_ni) begin
      for (s = 0; s < hkrb_pkg::KeySlots; s++) kb_slots[s] = 8'h00;
      kb_mods          = 8'h00;
      kb_caps_pending  = 1'b0;
      kb_caps_on       = 1'b0;
      kb_prev_caps_led = 1'b0;
      kb_last_leds     = hkrb_pkg::HostLedsRst;
      kb_caps_locking  = 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.slots   = {slot5_o, slot4_o, slot3_o, slot2_o, slot1_o, slot0_o};
        got.mods    = modifier_bits_o;
        got.changed = report_changed_o;
        got.send    = led_send_o;
        got.drive   = keyboard_led_drive_o;
        if (pending_reports.size() == 0) begin
          flag_mismatch("report word with no word outstanding");
        end else begin
          want = pending_reports.pop_front();
          for (s = 0; s < hkrb_pkg::ReportedSlots; s++) begin
            if (got.slots[s] !== want.slots[s])
              flag_mismatch($sformatf("slot%0d got %h expected %h",
                                      s, got.slots[s], want.slots[s]));
          end
          if (got.mods !== want.mods)
            flag_mismatch($sformatf("modifier_bits got %h expected %h",
                                    got.mods, want.mods));
          if (got.changed !== want.changed)
            flag_mismatch($sformatf("report_changed got %b expected %b",
                                    got.changed, want.changed));
          if (got.send !== want.send)
            flag_mismatch($sformatf("led_send got %b expected %b", got.send, want.send));
          if (got.drive !== want.drive)
            flag_mismatch($sformatf("keyboard_led_drive got %h expected %h",
                                    got.drive, want.drive));
        end
        words_out++;
      end
      if (cfg_we_i) kb_caps_locking = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        want = next_report(command_i, key_code_i, released_i, host_leds_i);
        if (fix_valid) want = fix_report;
        pending_reports.push_back(want);
      end
    end
  end

  // The watchdog ends a run in which neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("hid_key_report_builder_top test failed");
        $finish;
      end
    end
  end

  // The receiver stalls in short random bursts, and holds off for a long
  // stretch whenever the stimulus asks for one.
  initial begin : receiver
    int   burst_left;
    int   holds_done;
    logic stall_next;
    out_stall_i = 1'b0;
    burst_left  = 0;
    holds_done  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (burst_left > 0) begin
          burst_left--;
          stall_next = 1'b1;
        end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
          burst_left = $urandom_range(1, 6) - 1;
          stall_next = 1'b1;
        end else begin
          stall_next = 1'b0;
        end
        out_stall_i <= stall_next;
      end
    end
  end

  function automatic stim_row_t word_row(input logic [1:0] cmd, input logic [7:0] code,
                                         input logic rel, input logic [7:0] leds);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_WORD;
    r.cmd       = cmd;
    r.code      = code;
    r.rel       = rel;
    r.leds      = leds;
    return r;
  endfunction

  // Attaches a report that can be read straight off the rules. All of these
  // rows come before any ordinary key is pressed, so the slots are empty.
  function automatic stim_row_t with_report(input stim_row_t r, input logic [7:0] mods,
                                            input logic changed, input logic send,
                                            input logic [2:0] drive);
    stim_row_t t;
    t              = r;
    t.fixed        = 1'b1;
    t.want.slots   = '0;
    t.want.mods    = mods;
    t.want.changed = changed;
    t.want.send    = send;
    t.want.drive   = drive;
    return t;
  endfunction

  function automatic stim_row_t cfg_row(input logic value);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_CFG;
    r.cfg_value = value;
    return r;
  endfunction

  // Presents one word and returns at the edge where it is taken. Valid is
  // left high; the next call or a drain decides what happens to it.
  task automatic offer_word(input logic [1:0] cmd, input logic [7:0] code, input logic rel,
                            input logic [7:0] leds, input logic fixed, input report_t want);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    key_code_i  <= code;
    released_i  <= rel;
    host_leds_i <= leds;
    fix_valid   <= fixed;
    fix_report  <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops offering words and waits until every report owed has come out.
  // The first edge lets the monitor record the word taken at the current one.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_caps_locking(input logic value);
    drain_reports();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly typing-like traffic: keys from a small pool, Caps Lock, modifiers,
  // poll ticks and LED updates. The rest is noise with every field random.
  task automatic random_word();
    logic [1:0]  cmd;
    logic [7:0]  code;
    logic [7:0]  leds;
    logic        rel;
    int unsigned pick;
    int unsigned which;
    cmd   = 2'($urandom_range(0, 3));
    code  = 8'($urandom_range(0, 255));
    leds  = 8'($urandom_range(0, 255));
    rel   = 1'($urandom_range(0, 1));
    pick  = $urandom_range(0, 99);
    which = $urandom_range(0, 9);
    if (pick < 50) begin
      cmd = hkrb_pkg::CMD_KEY;
      rel = ($urandom_range(0, 9) < 4);
      if (which < 6)       code = TypingBase + 8'($urandom_range(0, 9));
      else if (which < 8)  code = hkrb_pkg::CapsCode;
      else if (which == 8) code = hkrb_pkg::ModFirst + 8'($urandom_range(0, 7));
    end else if (pick < 72) begin
      cmd = hkrb_pkg::CMD_POLL;
    end else if (pick < 90) begin
      cmd = hkrb_pkg::CMD_LED;
      // Small values make the caps bit flip often and repeats likely.
      if (which < 6) leds = 8'($urandom_range(0, 3));
    end else if (pick < 95) begin
      cmd = CmdUnused;
    end
    offer_word(cmd, code, rel, leds, 1'b0, '0);
  endtask

  initial begin : stimulus
    int ph;
    int n;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = hkrb_pkg::CMD_KEY;
    key_code_i    = 8'h00;
    released_i    = 1'b0;
    host_leds_i   = 8'h00;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    fix_valid     = 1'b0;
    fix_report    = '0;
    sender_gaps   = 1'b1;
    stall_bursts  = 1'b1;
    hold_requests = 0;
    mismatches    = 0;
    words_out     = 0;
    quiet_cycles  = 0;

    // Directed part. The first rows start from reset with caps locking on and
    // touch only modifiers and LEDs, so their reports are typed in.
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_POLL, 8'h00, 1'b0, 8'hA5),
                                        8'h00, 1'b0, 1'b0, 3'd0));
    // An unmapped key still counts as a handled key event.
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_KEY, 8'h00, 1'b0, 8'h00),
                                        8'h00, 1'b1, 1'b0, 3'd0));
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::ModFirst,
                                                 1'b0, 8'h00),
                                        8'h01, 1'b1, 1'b0, 3'd0));
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::ModLast,
                                                 1'b0, 8'h00),
                                        8'h81, 1'b1, 1'b0, 3'd0));
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::ModFirst,
                                                 1'b1, 8'h00),
                                        8'h80, 1'b1, 1'b0, 3'd0));
    // The same LED value as after reset sends nothing.
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_LED, 8'h00, 1'b0, 8'hFF),
                                        8'h80, 1'b0, 1'b0, 3'd0));
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_LED, 8'hFF, 1'b1, 8'h00),
                                        8'h80, 1'b0, 1'b1, 3'd7));
    directed_rows.push_back(with_report(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::ModLast,
                                                 1'b1, 8'h00),
                                        8'h00, 1'b1, 1'b0, 3'd7));
    // Slot handling: a repeated press, filling every slot, a press that is
    // lost, a release that shifts, and a release of a key not held.
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h04, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h04, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'hFF, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h05, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h06, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h07, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h08, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h09, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'hFF, 1'b1, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, 8'h0A, 1'b1, 8'h00));
    // Caps Lock as a toggle: a press, a press with no change of state, the
    // release on the next poll, a poll with nothing to do, a release that
    // turns the lock off, the host LED taking the lock back on.
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::CapsCode, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::CapsCode, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_POLL, hkrb_pkg::CapsCode, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_POLL, hkrb_pkg::CapsCode, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::CapsCode, 1'b1, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_LED, 8'h00, 1'b0, 8'h02));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_POLL, 8'h00, 1'b0, 8'h02));
    directed_rows.push_back(word_row(CmdUnused, 8'h39, 1'b1, 8'h5A));
    // With locking off, Caps Lock is an ordinary key and the LED is only sent.
    directed_rows.push_back(cfg_row(1'b0));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::CapsCode, 1'b0, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_KEY, hkrb_pkg::CapsCode, 1'b1, 8'h00));
    directed_rows.push_back(word_row(hkrb_pkg::CMD_LED, 8'h00, 1'b0, 8'h00));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_caps_locking(directed_rows[i].cfg_value);
      end else begin
        offer_word(directed_rows[i].cmd, directed_rows[i].code, directed_rows[i].rel,
                   directed_rows[i].leds, directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    // Random part, in phases with the register changed between them.
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       write_caps_locking(1'b1);
        1:       write_caps_locking(1'b0);
        2:       write_caps_locking(1'b1);
        3:       write_caps_locking(1'($urandom_range(0, 1)));
        default: begin
          // The last phase runs at full rate on both sides.
          write_caps_locking(1'b1);
          sender_gaps = 1'b0;
          stall_bursts <= 1'b0;
        end
      endcase
      // A long hold-off on the output while words keep coming fills the
      // block until it stalls its input.
      if (ph == 1) hold_requests <= hold_requests + 1;
      for (n = 0; n < PhaseWords; n++) begin
        // Halfway through one phase the sender waits for the block to empty.
        if (ph == 2 && n == PhaseWords / 2) drain_reports();
        random_word();
      end
    end

    drain_reports();
    if (mismatches == 0) begin
      $display("hid_key_report_builder_top test passed");
    end else begin
      $display("hid_key_report_builder_top test failed");
    end
    $finish;
  end

endmodule
